@@ src/utf8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package utf8u16_pkg;

  // Status codes carried by a status result
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_STRAY = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // Default depth of the record queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ACC_W   = 22;
  localparam int CNT_W   = 32;
  localparam int UNIT_W  = 16;
  localparam int OUT_DATA_W = 88;

  // Surrogate bases and the code point offset of the pair form
  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [ACC_W-1:0]  PAIR_OFFSET  = 22'h010000;

  // All results caused by one input byte: units first, then an optional status
  typedef struct packed {
    logic [1:0]        nunits;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic              has_status;
    logic [2:0]        status;
    logic [CNT_W-1:0]  consumed;
    logic [CNT_W-1:0]  written;
  } rec_t;

endpackage

@@ src/utf8u16_front.sv @@
// Front end: takes UTF-8 bytes, gathers sequences, checks room, builds records.
// Depends on utf8u16_pkg.
module utf8u16_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        end_mark,
  input  logic                        cfg_valid,
  input  logic [utf8u16_pkg::CNT_W-1:0] cfg_data,
  output logic                        push,
  output utf8u16_pkg::rec_t           rec
);
  import utf8u16_pkg::*;

  logic [CNT_W-1:0] capacity;
  logic [ACC_W-1:0] acc, acc_next;
  logic [2:0]       expected, expected_next;
  logic [2:0]       seen, seen_next;
  logic [CNT_W-1:0] consumed, consumed_next;
  logic [CNT_W-1:0] written, written_next;
  logic             discarding, discarding_next;

  logic             accept;
  logic [CNT_W:0]   room_diff;
  logic             no_room, one_left;

  assign accept    = in_valid && in_ready;
  assign room_diff = {1'b0, capacity} - {1'b0, written};
  assign no_room   = room_diff[CNT_W] || (room_diff == '0);
  assign one_left  = (room_diff == {{CNT_W{1'b0}}, 1'b1});

  // Sequence decode and record build
  always_comb begin
    logic             done;
    logic             has_err;
    logic [2:0]       err;
    logic [2:0]       len;
    logic             need2;
    logic [ACC_W-1:0] v;
    logic [2:0]       seen_inc;

    done = 1'b0;
    has_err = 1'b0;
    err = ST_OK;
    len = 3'd0;
    need2 = 1'b0;
    v = '0;
    seen_inc = seen + 3'd1;

    acc_next = acc;
    expected_next = expected;
    seen_next = seen;
    consumed_next = consumed;
    written_next = written;
    discarding_next = discarding;
    rec = '0;

    if (discarding) begin
      if (end_mark) begin
        discarding_next = 1'b0;
      end
    end else begin
      if (expected == 3'd0) begin
        priority if (!data_byte[7]) begin
          acc_next = {{(ACC_W-8){1'b0}}, data_byte};
          len = 3'd1;
          done = 1'b1;
        end else if (!data_byte[6]) begin
          has_err = 1'b1;
          err = ST_STRAY;
        end else if (!data_byte[5]) begin
          acc_next = {{(ACC_W-5){1'b0}}, data_byte[4:0]};
          expected_next = 3'd2;
          seen_next = 3'd1;
        end else if (!data_byte[4]) begin
          acc_next = {{(ACC_W-4){1'b0}}, data_byte[3:0]};
          expected_next = 3'd3;
          seen_next = 3'd1;
        end else begin
          // F8-FF also count as 4-byte leads
          acc_next = {{(ACC_W-4){1'b0}}, data_byte[3:0]};
          expected_next = 3'd4;
          seen_next = 3'd1;
        end
      end else if (data_byte[7:6] == 2'b10) begin
        acc_next = {acc[ACC_W-7:0], data_byte[5:0]};
        seen_next = seen_inc;
        if (seen_inc >= expected) begin
          len = expected;
          done = 1'b1;
        end
      end else begin
        has_err = 1'b1;
        err = ST_BAD;
      end

      if (!has_err && !done && end_mark) begin
        has_err = 1'b1;
        err = ST_TRUNC;
      end

      // Finished sequence: room check, then units
      if (!has_err && done) begin
        need2 = (acc_next[ACC_W-1:16] != '0);
        v = acc_next - PAIR_OFFSET;
        if (no_room || (need2 && one_left)) begin
          has_err = 1'b1;
          err = ST_FULL;
        end else begin
          if (need2) begin
            rec.nunits = 2'd2;
            rec.unit0 = HI_SURR_BASE | {6'b0, v[19:10]};
            rec.unit1 = LO_SURR_BASE | {6'b0, v[9:0]};
          end else begin
            rec.nunits = 2'd1;
            rec.unit0 = acc_next[UNIT_W-1:0];
          end
          consumed_next = consumed + {{(CNT_W-3){1'b0}}, len};
          written_next = written + (need2 ? CNT_W'(2) : CNT_W'(1));
          acc_next = '0;
          expected_next = 3'd0;
          seen_next = 3'd0;
          if (end_mark) begin
            rec.has_status = 1'b1;
            rec.status = ST_OK;
            rec.consumed = consumed_next;
            rec.written = written_next;
            consumed_next = '0;
            written_next = '0;
          end
        end
      end

      // Error: report counts before the failing sequence, then clear
      if (has_err) begin
        rec.has_status = 1'b1;
        rec.status = err;
        rec.consumed = consumed;
        rec.written = written;
        acc_next = '0;
        expected_next = 3'd0;
        seen_next = 3'd0;
        consumed_next = '0;
        written_next = '0;
        discarding_next = !end_mark;
      end
    end
  end

  assign push = accept && ((rec.nunits != 2'd0) || rec.has_status);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= '0;
      acc        <= '0;
      expected   <= '0;
      seen       <= '0;
      consumed   <= '0;
      written    <= '0;
      discarding <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        acc        <= acc_next;
        expected   <= expected_next;
        seen       <= seen_next;
        consumed   <= consumed_next;
        written    <= written_next;
        discarding <= discarding_next;
      end
    end
  end

endmodule

@@ src/utf8u16_queue.sv @@
// Short record queue between the front and back ends.
// Depends on utf8u16_pkg (rec_t).
module utf8u16_queue #(
  parameter int DEPTH = utf8u16_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8u16_pkg::rec_t push_rec,
  input  logic              pop,
  output utf8u16_pkg::rec_t head,
  output logic              empty,
  output logic              full
);
  import utf8u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  rec_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_QW'(DEPTH));
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

@@ src/utf8u16_back.sv @@
// Back end: holds one record and emits its results one per cycle while out_ready is high.
// Depends on utf8u16_pkg.
module utf8u16_back (
  input  logic              clk,
  input  logic              rst,
  input  utf8u16_pkg::rec_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_status,
  output logic [utf8u16_pkg::UNIT_W-1:0] code_unit,
  output logic [2:0]        status,
  output logic [utf8u16_pkg::CNT_W-1:0] bytes_consumed,
  output logic [utf8u16_pkg::CNT_W-1:0] units_written,
  output logic              run_last
);
  import utf8u16_pkg::*;

  rec_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [1:0] total;
  logic       is_unit;
  logic       taken;

  assign total    = cur.nunits + {1'b0, cur.has_status};
  assign is_unit  = (idx < cur.nunits);
  assign run_last = (idx == total - 2'd1);
  assign taken    = cur_valid && out_ready;
  assign pop      = !empty && (!cur_valid || (taken && run_last));

  // Result fields from the held record
  assign out_valid      = cur_valid;
  assign is_status      = !is_unit;
  assign code_unit      = !is_unit ? '0 : ((idx == 2'd0) ? cur.unit0 : cur.unit1);
  assign status         = is_unit ? ST_OK : cur.status;
  assign bytes_consumed = is_unit ? '0 : cur.consumed;
  assign units_written  = is_unit ? '0 : cur.written;

  // Payload of the held record
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Held-record valid and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (taken) begin
        if (run_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule

@@ src/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: front end, record queue, back end.
// Depends on utf8u16_pkg, utf8u16_front, utf8u16_queue, utf8u16_back.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata[7:0] byte, tlast end of buffer
//  m_*       out  m_tvalid / m_tready    tdata unit/status/counts, tuser, tlast
//  cfg_*     in   cfg_valid / cfg_ready  cfg_data output capacity
//
// One input byte is taken per cycle while s_tready is high, decoded in that cycle.
// Results leave one per cycle from the back end's held record while m_tready is
// high, so a byte that makes a surrogate pair plus a status yields three results.
// The record queue (QUEUE_DEPTH entries) absorbs that; s_tready drops only
// when it is full. Reset is synchronous; capacity resets to 0, no clearing pass.
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = utf8u16_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [7:0]                            s_tdata,  // [7:0] data_byte
  input  logic                                  s_tlast,  // end_of_buffer
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [15:0] code_unit, [18:16] status, [50:19] bytes_consumed,
  // [82:51] units_written, [87:83] zero
  output logic [utf8u16_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                  m_tuser,  // is_status
  output logic                                  m_tlast,  // run_last
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [utf8u16_pkg::CNT_W-1:0]         cfg_data  // output_capacity
);
  import utf8u16_pkg::*;

  rec_t              front_rec;
  rec_t              head;
  logic              push, pop, empty, full;
  logic [UNIT_W-1:0] code_unit;
  logic [2:0]        status;
  logic [CNT_W-1:0]  bytes_consumed;
  logic [CNT_W-1:0]  units_written;

  assign s_tready  = !full;
  assign cfg_ready = 1'b1;

  utf8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .data_byte (s_tdata),
    .end_mark  (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .rec       (front_rec)
  );

  utf8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (front_rec),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  utf8u16_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .is_status      (m_tuser),
    .code_unit      (code_unit),
    .status         (status),
    .bytes_consumed (bytes_consumed),
    .units_written  (units_written),
    .run_last       (m_tlast)
  );

  // Pack result fields, lowest field first
  assign m_tdata = {5'b0, units_written, bytes_consumed, status, code_unit};

endmodule

@@ src/utf8u16_checker.sv @@
// Port-level checks for the transcoder, bound to the top level.
// Depends on utf8u16_pkg and utf8_to_utf16_transcoder.
module utf8u16_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [utf8u16_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                               m_tuser,
  input logic                               m_tlast
);
  import utf8u16_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A status always closes the run of results for its byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("status result without run_last");

  // A status result carries no code unit
  a_status_no_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000)
    else $error("status result with a code unit");

  // A unit result carries no status, counts or padding
  a_unit_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[OUT_DATA_W-1:16] == '0)
    else $error("unit result with status fields set");

endmodule

bind utf8_to_utf16_transcoder utf8u16_checker u_checker (.*);
